@@ design/rac_pkg.sv @@
// Package with the command codes, the sequencer states and the widths of the rational ALU.
package rac_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CntWidth  = $clog2(DataWidth + 1);

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_MULF  = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_SUB   = 3'd3,
    CMD_MULI  = 3'd4,
    CMD_RECIP = 3'd5,
    CMD_SIMP  = 3'd6,
    CMD_NOP   = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_COMBINE,
    ST_GCD,
    ST_DIV,
    ST_DIVDONE,
    ST_OUT
  } state_e;

endpackage

@@ design/rational_accumulator_alu.sv @@
// Rational accumulator ALU: a numerator/denominator pair updated by bit-serial arithmetic.
// Load, reciprocal, the unused code and a simplify that keeps the fraction go straight to the
// output; multiply by integer runs one shift-add pass; multiply, add and subtract run two
// shift-add passes, one multiplier bit a cycle.
// Simplify runs Euclid with a bit-serial remainder, then two divides by the GCD.
// One item at a time; the next beat is taken the cycle after the result leaves. Reset is
// asynchronous, active low, and sets the fraction to 0 / 1.
module rational_accumulator_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command [2:0], operand_numerator [34:3], operand_denominator [66:35], zeros [71:67]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_numerator [31:0], result_denominator [63:32]
  output logic [63:0] m_axis_tdata
);
  import rac_pkg::*;

  localparam int unsigned W = DataWidth;

  state_e        state_q, state_d;
  cmd_e          cmd_q, cmd_d;
  logic [W-1:0]  num_q, num_d, den_q, den_d;
  logic [W-1:0]  opn_q, opn_d, opd_q, opd_d;
  // Shift-add multiplier: multiplicand shifts left, multiplier shifts right.
  logic [W-1:0]  mcand_q, mcand_d, mplier_q, mplier_d, prod_q, prod_d;
  // Second accumulator on the first pass: the denominator times the same multiplier bits.
  logic [W-1:0]  mcand2_q, mcand2_d, prod2_q, prod2_d;
  logic [W-1:0]  p1_q, p1_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  // GCD registers a and b; a mod b is worked out in the divider registers below.
  logic [W-1:0]  ga_q, ga_d, gb_q, gb_d;
  // Restoring divider: remainder, quotient/dividend shift register, first quotient.
  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, q1_q, q1_d;
  logic          phase_q, phase_d;
  logic [W:0]    rem_sh;
  logic [W:0]    trial;

  wire in_beat = s_axis_tvalid && s_axis_tready;

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      num_q   <= '0;
      den_q   <= W'(1);
    end else begin
      state_q <= state_d;
      num_q   <= num_d;
      den_q   <= den_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    opn_q    <= opn_d;
    opd_q    <= opd_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    prod_q   <= prod_d;
    mcand2_q <= mcand2_d;
    prod2_q  <= prod2_d;
    p1_q     <= p1_d;
    cnt_q    <= cnt_d;
    ga_q     <= ga_d;
    gb_q     <= gb_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    q1_q     <= q1_d;
    phase_q  <= phase_d;
  end

  // One restoring divide step of quo_q (dividend bits) by gb_q or the GCD in ga_q.
  always_comb begin
    rem_sh = {rem_q, quo_q[W-1]};
    trial  = rem_sh - {1'b0, (state_q == ST_GCD) ? gb_q : ga_q};
  end

  // Next state and datapath control.
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    num_d    = num_q;
    den_d    = den_q;
    opn_d    = opn_q;
    opd_d    = opd_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    prod_d   = prod_q;
    mcand2_d = mcand2_q;
    prod2_d  = prod2_q;
    p1_d     = p1_q;
    cnt_d    = cnt_q;
    ga_d     = ga_q;
    gb_d     = gb_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    q1_d     = q1_q;
    phase_d  = phase_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_beat) begin
          cmd_d = cmd_e'(s_axis_tdata[2:0]);
          opn_d = s_axis_tdata[34:3];
          opd_d = s_axis_tdata[66:35];
          cnt_d = '0;
          prod_d = '0;
          mcand2_d = den_q;
          prod2_d  = '0;
          unique case (cmd_e'(s_axis_tdata[2:0]))
            CMD_LOAD: begin
              num_d   = s_axis_tdata[34:3];
              den_d   = s_axis_tdata[66:35];
              state_d = ST_OUT;
            end
            CMD_RECIP: begin
              num_d   = den_q;
              den_d   = num_q;
              state_d = ST_OUT;
            end
            CMD_NOP: state_d = ST_OUT;
            CMD_SIMP: begin
              if (!num_q[W-1] && num_q != '0 && !den_q[W-1] && den_q != '0) begin
                ga_d    = num_q;
                gb_d    = den_q;
                rem_d   = '0;
                quo_d   = num_q;
                state_d = ST_GCD;
              end else begin
                state_d = ST_OUT;
              end
            end
            CMD_MULI: begin
              mcand_d = num_q;
              mplier_d = s_axis_tdata[34:3];
              state_d = ST_MUL2;
            end
            CMD_MULF: begin
              mcand_d = num_q;
              mplier_d = s_axis_tdata[34:3];
              state_d = ST_MUL1;
            end
            default: begin
              // Add and subtract: first num*opd, and den*opd alongside.
              mcand_d = num_q;
              mplier_d = s_axis_tdata[66:35];
              state_d = ST_MUL1;
            end
          endcase
        end
      end
      ST_MUL1, ST_MUL2: begin
        // One bit of the multiplier per cycle.
        if (mplier_q[0]) prod_d = prod_q + mcand_q;
        if (state_q == ST_MUL1) begin
          if (mplier_q[0]) prod2_d = prod2_q + mcand2_q;
          mcand2_d = mcand2_q << 1;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(W - 1)) begin
          cnt_d = '0;
          if (state_q == ST_MUL1) begin
            p1_d    = mplier_q[0] ? prod_q + mcand_q : prod_q;
            prod_d  = '0;
            mcand_d = den_q;
            mplier_d = (cmd_q == CMD_MULF) ? opd_q : opn_q;
            state_d = ST_MUL2;
          end else begin
            state_d = ST_COMBINE;
          end
        end
      end
      ST_COMBINE: begin
        // prod_q holds the second product, p1_q the first, prod2_q den*opd on add/sub.
        unique case (cmd_q)
          CMD_MULI: num_d = prod_q;
          CMD_MULF: begin
            num_d = p1_q;
            den_d = prod_q;
          end
          CMD_ADD: begin
            num_d = prod_q + p1_q;
            den_d = prod2_q;
          end
          default: begin
            num_d = p1_q - prod_q;
            den_d = prod2_q;
          end
        endcase
        state_d = ST_OUT;
      end
      ST_GCD: begin
        // Euclid step: a mod b by a restoring divide, one bit a cycle.
        rem_d = trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
        quo_d = quo_q << 1;
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(W - 1)) begin
          cnt_d = '0;
          if ((trial[W] ? rem_sh[W-1:0] : trial[W-1:0]) == '0) begin
            // b is the GCD; divide the numerator first.
            ga_d    = gb_q;
            rem_d   = '0;
            quo_d   = num_q;
            phase_d = 1'b0;
            state_d = ST_DIV;
          end else begin
            ga_d  = gb_q;
            gb_d  = trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
            quo_d = gb_q;
            rem_d = '0;
          end
        end
      end
      ST_DIV: begin
        // Restoring divide by the GCD; quotient bits enter at the bottom.
        rem_d = trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
        quo_d = {quo_q[W-2:0], ~trial[W]};
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(W - 1)) begin
          cnt_d = '0;
          if (!phase_q) begin
            q1_d    = {quo_q[W-2:0], ~trial[W]};
            quo_d   = den_q;
            rem_d   = '0;
            phase_d = 1'b1;
          end else begin
            state_d = ST_DIVDONE;
          end
        end
      end
      ST_DIVDONE: begin
        num_d   = q1_q;
        den_d   = quo_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tdata = {den_q, num_q};

  // Checks on the sequencer.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready and valid together");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_gcd_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCD) |-> (ga_q != '0 && gb_q != '0)) else $error("gcd operand zero");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tdata[2:0] == CMD_LOAD)
      |=> m_axis_tdata[31:0] == $past(s_axis_tdata[34:3]))
    else $error("load lost");

endmodule
